### hdl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DEFAULT_OPERAND_BITS = 31;
  localparam int SECRET_BITS          = 8;

  // configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = 2'd1;

  localparam int MODULUS_RESET = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LAUNCH,
    ST_MULTIPLY,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

### hdl/mexp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: result = x * y mod m, x < m.
// Scans y from the MSB, one double step and one conditional add per bit.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int OPERAND_BITS = mexp_pkg::DEFAULT_OPERAND_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [OPERAND_BITS-1:0] x,
  input  wire logic [OPERAND_BITS-1:0] y,
  input  wire logic [OPERAND_BITS-1:0] m,
  output logic                         done,
  output logic [OPERAND_BITS-1:0]      result
);

  localparam int CNT_BITS = $clog2(OPERAND_BITS);
  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(OPERAND_BITS - 1);

  logic                    busy;
  logic                    phase;   // 0: double, 1: add x
  logic [CNT_BITS-1:0]     cnt;
  logic [OPERAND_BITS-1:0] acc;
  logic [OPERAND_BITS-1:0] xr;
  logic [OPERAND_BITS-1:0] yr;

  logic [OPERAND_BITS-1:0] addend;
  logic [OPERAND_BITS:0]   sum;
  logic [OPERAND_BITS:0]   folded;
  logic [OPERAND_BITS-1:0] acc_next;

  // both operands stay below m, so one conditional subtract reduces the sum
  always_comb begin
    addend   = phase ? xr : acc;
    sum      = {1'b0, acc} + {1'b0, addend};
    folded   = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
    acc_next = folded[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        acc   <= '0;
        xr    <= x;
        yr    <= y;
      end else if (busy) begin
        if (!phase) begin
          acc   <= acc_next;
          phase <= 1'b1;
        end else begin
          if (yr[OPERAND_BITS-1]) begin
            acc <= acc_next;
          end
          yr    <= yr << 1;
          phase <= 1'b0;
          cnt   <= cnt + 1'b1;
          if (cnt == LAST_BIT) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = acc;

endmodule
`default_nettype wire

### hdl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base to the configured exponent, reduced by the modulus.
// ----------------------------------------------------------------------------
// One item at a time. The base is first reduced by the modulus, then the
// exponent is scanned LSB first over all OPERAND_BITS (N) bits; per bit the
// running product and the power square are formed in parallel on two
// bit-serial modular multipliers. The run time of an item is independent of
// operand values. A finished result sits in an output register while the
// next item is taken. A zero exponent gives 1; a modulus below two gives 0.
// The user must see that the config registers are written only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_BITS = mexp_pkg::DEFAULT_OPERAND_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // config write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [OPERAND_BITS-1:0]            cfg_data,
  // input items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [OPERAND_BITS-1:0]            base_value,
  // result items
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [OPERAND_BITS-1:0]                 residue,
  output logic [mexp_pkg::SECRET_BITS-1:0]        secret_byte
);

  localparam int CNT_BITS = $clog2(OPERAND_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OPERAND_BITS - 1);
  localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

  mexp_pkg::state_t state, state_next;

  logic [OPERAND_BITS-1:0] private_exponent;
  logic [OPERAND_BITS-1:0] modulus;

  logic [OPERAND_BITS-1:0] prod;
  logic [OPERAND_BITS-1:0] pw;
  logic [OPERAND_BITS-1:0] exp_sh;
  logic [CNT_BITS-1:0]     step_cnt;

  logic                    in_accept;
  logic                    start_a;
  logic                    start_b;
  logic                    load_out;
  logic                    done_a;
  logic                    done_b;
  logic [OPERAND_BITS-1:0] x_a;
  logic [OPERAND_BITS-1:0] y_a;
  logic [OPERAND_BITS-1:0] res_a;
  logic [OPERAND_BITS-1:0] res_b;
  logic                    mod_small;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != mexp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign mod_small = ~|modulus[OPERAND_BITS-1:1];

  // unit A: base reduction (1 * base mod m), then the product update
  assign x_a = (state == mexp_pkg::ST_IDLE) ? ONE : prod;
  assign y_a = (state == mexp_pkg::ST_IDLE) ? base_value : pw;

  mexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mul_prod (
    .clk    (clk),
    .rst    (rst),
    .start  (start_a),
    .x      (x_a),
    .y      (y_a),
    .m      (modulus),
    .done   (done_a),
    .result (res_a)
  );

  // unit B: power squaring
  mexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mul_square (
    .clk    (clk),
    .rst    (rst),
    .start  (start_b),
    .x      (pw),
    .y      (pw),
    .m      (modulus),
    .done   (done_b),
    .result (res_b)
  );

  always_comb begin
    state_next = state;
    start_a    = 1'b0;
    start_b    = 1'b0;
    load_out   = 1'b0;
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_accept) begin
          start_a    = 1'b1;
          state_next = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (done_a) begin
          state_next = mexp_pkg::ST_LAUNCH;
        end
      end
      mexp_pkg::ST_LAUNCH: begin
        start_a    = 1'b1;
        start_b    = 1'b1;
        state_next = mexp_pkg::ST_MULTIPLY;
      end
      mexp_pkg::ST_MULTIPLY: begin
        // both units run the same length and finish together
        if (done_b) begin
          state_next = (step_cnt == LAST_STEP) ? mexp_pkg::ST_FINISH
                                               : mexp_pkg::ST_LAUNCH;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      private_exponent <= '0;
      modulus          <= OPERAND_BITS'(mexp_pkg::MODULUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mexp_pkg::CFG_EXPONENT: private_exponent <= cfg_data;
        mexp_pkg::CFG_MODULUS:  modulus          <= cfg_data;
        default: ;
      endcase
    end
  end

  // exponent scan datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      prod     <= ONE;
      exp_sh   <= private_exponent;
      step_cnt <= '0;
    end
    if (state == mexp_pkg::ST_REDUCE && done_a) begin
      pw <= res_a;
    end
    if (state == mexp_pkg::ST_MULTIPLY && done_b) begin
      if (exp_sh[0]) begin
        prod <= res_a;
      end
      pw       <= res_b;
      exp_sh   <= exp_sh >> 1;
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      residue <= mod_small ? '0 : prod;
    end
  end

  assign secret_byte = residue[mexp_pkg::SECRET_BITS-1:0];

endmodule
`default_nettype wire

### dv/mexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_checker
// Watches the register, base and result channels of the modular
// exponentiation block, keeps its own copy of the exponent and modulus,
// predicts the residue of every accepted base and compares each result
// in order. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int OPERAND_BITS = mexp_pkg::DEFAULT_OPERAND_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic                                cfg_ready,
  input  wire logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [OPERAND_BITS-1:0]             cfg_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [OPERAND_BITS-1:0]             base_value,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [OPERAND_BITS-1:0]             residue,
  input  wire logic [mexp_pkg::SECRET_BITS-1:0]    secret_byte,
  output int                                       mismatches,
  output int                                       powers_pending,
  output int                                       results_seen
);

  localparam int WIDE_BITS = 2 * OPERAND_BITS;

  typedef struct packed {
    logic [OPERAND_BITS-1:0]          residue;
    logic [mexp_pkg::SECRET_BITS-1:0] secret_byte;
  } power_result_t;

  power_result_t           expected_powers[$];
  logic [OPERAND_BITS-1:0] exponent_reg;
  logic [OPERAND_BITS-1:0] modulus_reg;

  initial begin
    mismatches     = 0;
    powers_pending = 0;
    results_seen   = 0;
  end

  // right-to-left square and multiply, full double-width products
  function automatic logic [OPERAND_BITS-1:0] raise_mod(
    input logic [OPERAND_BITS-1:0] b,
    input logic [OPERAND_BITS-1:0] e,
    input logic [OPERAND_BITS-1:0] m
  );
    logic [WIDE_BITS-1:0] acc;
    logic [WIDE_BITS-1:0] pw;
    logic [WIDE_BITS-1:0] mw;
    if (m < 2) return '0;
    mw  = WIDE_BITS'(m);
    acc = WIDE_BITS'(1);
    pw  = WIDE_BITS'(b % m);
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (e[i]) acc = (acc * pw) % mw;
      pw = (pw * pw) % mw;
    end
    return acc[OPERAND_BITS-1:0];
  endfunction

  always @(posedge clk) begin : track
    power_result_t           want;
    logic [OPERAND_BITS-1:0] r;
    if (rst) begin
      exponent_reg = '0;
      modulus_reg  = OPERAND_BITS'(mexp_pkg::MODULUS_RESET);
      expected_powers.delete();
      powers_pending <= 0;
    end else begin
      // retire before push: a result can never belong to a base taken this edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_powers.size() == 0) begin
          $error("result with no base pending: residue %0d, secret_byte %0d",
                 residue, secret_byte);
          mismatches++;
        end else begin
          want = expected_powers.pop_front();
          if (residue !== want.residue) begin
            $error("residue: expected %0d, got %0d", want.residue, residue);
            mismatches++;
          end
          if (secret_byte !== want.secret_byte) begin
            $error("secret_byte: expected %0d, got %0d", want.secret_byte, secret_byte);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        r                = raise_mod(base_value, exponent_reg, modulus_reg);
        want.residue     = r;
        want.secret_byte = r[mexp_pkg::SECRET_BITS-1:0];
        expected_powers.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mexp_pkg::CFG_EXPONENT: exponent_reg = cfg_data;
          mexp_pkg::CFG_MODULUS:  modulus_reg  = cfg_data;
          default: ;  // unmapped index, write dropped
        endcase
      end
      powers_pending <= expected_powers.size();
    end
  end

endmodule

### dv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Drives bases and register settings into the modular exponentiation block.
// A directed set covers the zero, unit and all-ones exponents, degenerate
// moduli, bases at or above the modulus and unmapped register writes; then
// random settings and bases follow with random gaps on both channels and a
// long output hold that backs the block up. Checking is done in mexp_checker.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  localparam int W = mexp_pkg::DEFAULT_OPERAND_BITS;
  localparam int IW = mexp_pkg::CFG_INDEX_BITS;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int MAX_GAP      = 12;
  localparam int LONG_HOLD    = 8000;
  localparam int TAIL_CYCLES  = 2200;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 268;

  logic                             clk         = 1'b0;
  logic                             rst         = 1'b1;
  logic                             cfg_valid   = 1'b0;
  logic                             cfg_ready;
  logic [IW-1:0]                    cfg_index   = '0;
  logic [W-1:0]                     cfg_data    = '0;
  logic                             in_valid    = 1'b0;
  logic                             in_stall;
  logic [W-1:0]                     base_value  = '0;
  logic                             out_valid;
  logic                             out_stall   = 1'b0;
  logic [W-1:0]                     residue;
  logic [mexp_pkg::SECRET_BITS-1:0] secret_byte;

  int  mismatches;
  int  powers_pending;
  int  results_seen;
  int  cycle_count      = 0;
  int  bases_sent       = 0;
  int  settings_applied = 0;
  int  long_holds       = 0;
  bit  steady_send      = 1'b0;
  logic hold_off_req    = 1'b0;

  always #6 clk = ~clk;

  modular_exponentiation #(.OPERAND_BITS(W)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .base_value(base_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .residue(residue), .secret_byte(secret_byte)
  );

  mexp_checker #(.OPERAND_BITS(W)) power_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .base_value(base_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .residue(residue), .secret_byte(secret_byte),
    .mismatches(mismatches), .powers_pending(powers_pending),
    .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d results pending", cycle_count, powers_pending);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_word();
    logic [31:0] r;
    r = $urandom();
    return r[W-1:0];
  endfunction

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return W'(1);
      2:       return ALL_ONES;
      3:       return W'($urandom_range(2, 64));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0:       return W'(2);
      1:       return W'(3);
      2:       return ALL_ONES;
      3:       return W'($urandom_range(0, 1));  // degenerate
      4, 5:    return W'($urandom_range(2, 300));
      6:       return rand_word() | (W'(1) << (W - 1));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return m - W'(1);
      3:       return m;
      4:       return m + W'(1);
      5, 6:    return W'($urandom_range(0, 15));
      default: return rand_word();
    endcase
  endfunction

  task automatic send_base(input logic [W-1:0] b);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    base_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bases_sent++;
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop offering and wait for every result; the extra edge lets the
  // pending count pick up a base taken on the last edge
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (powers_pending != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [W-1:0] exp_val, input logic [W-1:0] mod_val,
                                input bit both_spares);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(mexp_pkg::CFG_EXPONENT, exp_val);
      write_reg(mexp_pkg::CFG_MODULUS, mod_val);
    end else begin
      write_reg(mexp_pkg::CFG_MODULUS, mod_val);
      write_reg(mexp_pkg::CFG_EXPONENT, exp_val);
    end
    if (both_spares) begin
      write_reg(CFG_SPARE_LO, rand_word());
      write_reg(CFG_SPARE_HI, rand_word());
    end else if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, rand_word());
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // result side: random stalls, steady stretches, and a long hold on request
  initial begin : take_results
    int gap;
    int taken;
    bit steady_take;
    taken       = 0;
    steady_take = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 25 == 0) steady_take = ($urandom_range(0, 2) == 0);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        gap = LONG_HOLD;
        long_holds++;
      end else begin
        gap = steady_take ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : make_bases
    int          random_sent;
    int          phase;
    int          count;
    logic [W-1:0] exp_val;
    logic [W-1:0] mod_val;
    random_sent = 0;
    phase       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero exponent, modulus two
    send_base('0);
    send_base(ALL_ONES);

    // full-width exponent and modulus, base at the modulus folds to zero
    apply_settings(ALL_ONES, ALL_ONES, 1'b0);
    send_base('0);
    send_base(W'(1));
    send_base(W'(2));
    send_base(ALL_ONES);
    send_base(ALL_ONES - W'(1));
    send_base(W'(32'h5555_5555));
    send_base(W'(32'h2AAA_AAAA));

    // unit exponent: plain reduction of bases at and above the modulus
    apply_settings(W'(1), W'(13), 1'b0);
    send_base(ALL_ONES);
    send_base(W'(12));
    send_base(W'(13));
    send_base(W'(255));

    apply_settings('0, ALL_ONES, 1'b0);
    send_base(W'(5));

    // moduli below two give zero
    apply_settings(rand_word(), '0, 1'b0);
    send_base(W'(7));
    send_base(ALL_ONES);
    apply_settings(rand_word(), W'(1), 1'b0);
    send_base(W'(9));

    // writes to unmapped indexes must not disturb the live registers
    apply_settings(W'(65537), W'(1000003), 1'b1);
    send_base(W'(32'h4000_0000));
    send_base(W'(123456));

    apply_settings(W'(2), W'(2), 1'b0);
    send_base(W'(3));

    while (random_sent < RANDOM_ITEMS) begin
      exp_val = pick_exponent();
      mod_val = pick_modulus();
      apply_settings(exp_val, mod_val, 1'b0);
      steady_send = ($urandom_range(0, 3) == 0);
      count = $urandom_range(8, 30);
      // back-pressure phases: receiver holds off while bases keep coming
      if (phase == 2 || phase == 7) begin
        hold_off_req <= 1'b1;
        steady_send = 1'b1;
        count = 30;
      end
      repeat (count) send_base(pick_base(mod_val));
      random_sent += count;
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d bases raised under %0d register settings, %0d results compared",
             bases_sent, settings_applied, results_seen);
    $display("zero/unit/full exponents, moduli 0..2 and full width, %0d long output holds",
             long_holds);
    if (mismatches == 0 && powers_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
